/* rtl/message_header_deframer_defines.svh */
// ----------------------------------------------------------------------------
// message header deframer: assertion macros
// ----------------------------------------------------------------------------
`ifndef MESSAGE_HEADER_DEFRAMER_DEFINES_SVH
`define MESSAGE_HEADER_DEFRAMER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MHD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mhd: check failed");

// next-cycle implication
`define MHD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mhd: check failed");

`endif

/* rtl/mhd_pkg.sv */
// ----------------------------------------------------------------------------
// mhd_pkg
// Shared types and constants of the message header deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package mhd_pkg;

    localparam int HEADER_LEN = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAJOR = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TYPES = 2'd3;

    localparam logic [31:0] MAGIC_RESET = 32'h5049_4356;
    localparam logic [15:0] MAJOR_RESET = 16'd1;
    localparam logic [16:0] LIMIT_RESET = 17'h1_0000;
    localparam logic [15:0] TYPES_RESET = 16'h3FFE;

    typedef logic [3:0] status_t;

    localparam status_t ST_OK          = 4'd0;
    localparam status_t ST_HDR_TRUNC   = 4'd1;
    localparam status_t ST_MAGIC       = 4'd2;
    localparam status_t ST_HDR_SIZE    = 4'd3;
    localparam status_t ST_MAJOR       = 4'd4;
    localparam status_t ST_TYPE        = 4'd5;
    localparam status_t ST_TOO_LARGE   = 4'd6;
    localparam status_t ST_RESERVED0   = 4'd7;
    localparam status_t ST_RESERVED1   = 4'd8;
    localparam status_t ST_ZERO_SEQ    = 4'd9;
    localparam status_t ST_PLD_TRUNC   = 4'd10;
    localparam status_t ST_TRAILING    = 4'd11;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] major_version;
        logic [16:0] payload_limit;
        logic [15:0] known_type_mask;
    } cfg_t;

    // one finished message as classified by the front end
    typedef struct packed {
        logic        magic_good;
        logic        length_ok;
        logic        rsv_low_nz;
        logic        rsv_high_nz;
        logic [15:0] major;
        logic [15:0] minor;
        logic [15:0] mtype;
        logic [31:0] flags;
        logic [31:0] size;
        logic [63:0] seq;
        logic [63:0] corr;
        logic [63:0] conn_low;
        logic [63:0] conn_high;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

/* rtl/mhd_if.sv */
// ----------------------------------------------------------------------------
// mhd channel interfaces
// Byte input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface mhd_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [15:0] msg_type;
    logic [15:0] minor_version;
    logic [31:0] header_flags;
    logic [31:0] payload_size;
    logic [63:0] sequence_number;
    logic [63:0] correlation_tag;
    logic [63:0] connection_low;
    logic [63:0] connection_high;

    modport source (
        output valid, input ready,
        output status, output msg_type, output minor_version, output header_flags,
        output payload_size, output sequence_number, output correlation_tag,
        output connection_low, output connection_high
    );
    modport sink (
        input valid, output ready,
        input status, input msg_type, input minor_version, input header_flags,
        input payload_size, input sequence_number, input correlation_tag,
        input connection_low, input connection_high
    );
endinterface

`default_nettype wire

/* rtl/mhd_front.sv */
// ----------------------------------------------------------------------------
// mhd_front
// Takes message bytes, counts them, captures the header and checks the magic.
// ----------------------------------------------------------------------------
`default_nettype none

module mhd_front
    import mhd_pkg::*;
#(
    parameter int COUNT_WIDTH = 17
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    mhd_in_if.sink                 in_ch,
    input  cfg_t                   cfg,
    input  logic                   q_full,
    output logic                   push,
    output rec_t                   rec,
    output logic [COUNT_WIDTH-1:0] rec_count
);

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   magic_good_reg, magic_good_next;
    logic [15:0]            length_reg, length_next;
    logic [15:0]            major_reg, major_next;
    logic [15:0]            minor_reg, minor_next;
    logic [15:0]            mtype_reg, mtype_next;
    logic [31:0]            flags_reg, flags_next;
    logic [31:0]            size_reg, size_next;
    logic [31:0]            rsv_low_reg, rsv_low_next;
    logic [63:0]            seq_reg, seq_next;
    logic [63:0]            corr_reg, corr_next;
    logic [63:0]            conn_low_reg, conn_low_next;
    logic [63:0]            conn_high_reg, conn_high_next;
    logic [63:0]            rsv_high_reg, rsv_high_next;

    logic       accept;
    logic       in_hdr;
    logic [5:0] pos;
    logic [7:0] b;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign in_hdr      = count_reg < COUNT_WIDTH'(HEADER_LEN);
    assign pos         = count_reg[5:0];
    assign b           = in_ch.data_byte;
    assign count_next  = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    // header capture: every field is lane aligned, so low bits of pos pick the lane
    always_comb
    begin
        magic_good_next = magic_good_reg;
        length_next     = length_reg;
        major_next      = major_reg;
        minor_next      = minor_reg;
        mtype_next      = mtype_reg;
        flags_next      = flags_reg;
        size_next       = size_reg;
        rsv_low_next    = rsv_low_reg;
        seq_next        = seq_reg;
        corr_next       = corr_reg;
        conn_low_next   = conn_low_reg;
        conn_high_next  = conn_high_reg;
        rsv_high_next   = rsv_high_reg;
        if (in_hdr)
        begin
            if (pos inside {[6'd0:6'd3]})
            begin
                if (cfg.magic_word[{pos[1:0], 3'b000} +: 8] != b)
                begin
                    magic_good_next = 1'b0;
                end
            end
            else if (pos inside {[6'd4:6'd5]})
            begin
                length_next[{pos[0], 3'b000} +: 8] = b;
            end
            else if (pos inside {[6'd6:6'd7]})
            begin
                major_next[{pos[0], 3'b000} +: 8] = b;
            end
            else if (pos inside {[6'd8:6'd9]})
            begin
                minor_next[{pos[0], 3'b000} +: 8] = b;
            end
            else if (pos inside {[6'd10:6'd11]})
            begin
                mtype_next[{pos[0], 3'b000} +: 8] = b;
            end
            else if (pos inside {[6'd12:6'd15]})
            begin
                flags_next[{pos[1:0], 3'b000} +: 8] = b;
            end
            else if (pos inside {[6'd16:6'd19]})
            begin
                size_next[{pos[1:0], 3'b000} +: 8] = b;
            end
            else if (pos inside {[6'd20:6'd23]})
            begin
                rsv_low_next[{pos[1:0], 3'b000} +: 8] = b;
            end
            else if (pos inside {[6'd24:6'd31]})
            begin
                seq_next[{pos[2:0], 3'b000} +: 8] = b;
            end
            else if (pos inside {[6'd32:6'd39]})
            begin
                corr_next[{pos[2:0], 3'b000} +: 8] = b;
            end
            else if (pos inside {[6'd40:6'd47]})
            begin
                conn_low_next[{pos[2:0], 3'b000} +: 8] = b;
            end
            else if (pos inside {[6'd48:6'd55]})
            begin
                conn_high_next[{pos[2:0], 3'b000} +: 8] = b;
            end
            else
            begin
                rsv_high_next[{pos[2:0], 3'b000} +: 8] = b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            magic_good_reg <= 1'b1;
            length_reg     <= '0;
            major_reg      <= '0;
            minor_reg      <= '0;
            mtype_reg      <= '0;
            flags_reg      <= '0;
            size_reg       <= '0;
            rsv_low_reg    <= '0;
            seq_reg        <= '0;
            corr_reg       <= '0;
            conn_low_reg   <= '0;
            conn_high_reg  <= '0;
            rsv_high_reg   <= '0;
        end
        else if (accept)
        begin
            if (in_ch.end_of_buffer)
            begin
                // message goes to the queue, start over
                count_reg      <= '0;
                magic_good_reg <= 1'b1;
                length_reg     <= '0;
                major_reg      <= '0;
                minor_reg      <= '0;
                mtype_reg      <= '0;
                flags_reg      <= '0;
                size_reg       <= '0;
                rsv_low_reg    <= '0;
                seq_reg        <= '0;
                corr_reg       <= '0;
                conn_low_reg   <= '0;
                conn_high_reg  <= '0;
                rsv_high_reg   <= '0;
            end
            else
            begin
                count_reg      <= count_next;
                magic_good_reg <= magic_good_next;
                length_reg     <= length_next;
                major_reg      <= major_next;
                minor_reg      <= minor_next;
                mtype_reg      <= mtype_next;
                flags_reg      <= flags_next;
                size_reg       <= size_next;
                rsv_low_reg    <= rsv_low_next;
                seq_reg        <= seq_next;
                corr_reg       <= corr_next;
                conn_low_reg   <= conn_low_next;
                conn_high_reg  <= conn_high_next;
                rsv_high_reg   <= rsv_high_next;
            end
        end
    end

    assign push      = accept && in_ch.end_of_buffer;
    assign rec_count = count_next;

    always_comb
    begin
        rec.magic_good  = magic_good_next;
        rec.length_ok   = length_next == 16'(HEADER_LEN);
        rec.rsv_low_nz  = rsv_low_next != 32'd0;
        rec.rsv_high_nz = rsv_high_next != 64'd0;
        rec.major       = major_next;
        rec.minor       = minor_next;
        rec.mtype       = mtype_next;
        rec.flags       = flags_next;
        rec.size        = size_next;
        rec.seq         = seq_next;
        rec.corr        = corr_next;
        rec.conn_low    = conn_low_next;
        rec.conn_high   = conn_high_next;
    end

endmodule

`default_nettype wire

/* rtl/mhd_queue.sv */
// ----------------------------------------------------------------------------
// mhd_queue
// Two-entry queue of finished messages between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mhd_queue
    import mhd_pkg::*;
#(
    parameter int COUNT_WIDTH = 17
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  rec_t                   push_rec,
    input  logic [COUNT_WIDTH-1:0] push_count,
    input  logic                   pop,
    output rec_t                   head_rec,
    output logic [COUNT_WIDTH-1:0] head_count,
    output q_status_t              stat
);

    localparam int DEPTH  = 2;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    rec_t                   rec_q   [DEPTH];
    logic [COUNT_WIDTH-1:0] count_q [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0]      fill_reg, fill_next;

    assign stat.full  = fill_reg == FILL_W'(DEPTH);
    assign stat.empty = fill_reg == '0;
    assign head_rec   = rec_q[rd_ptr_reg];
    assign head_count = count_q[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            rec_q[wr_ptr_reg]   <= push_rec;
            count_q[wr_ptr_reg] <= push_count;
        end
    end

endmodule

`default_nettype wire

/* rtl/mhd_back.sv */
// ----------------------------------------------------------------------------
// mhd_back
// Judges a finished message in priority order and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mhd_back
    import mhd_pkg::*;
#(
    parameter int COUNT_WIDTH = 17
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  q_status_t              q_stat,
    input  rec_t                   head_rec,
    input  logic [COUNT_WIDTH-1:0] head_count,
    output logic                   pop,
    mhd_out_if.source              out_ch
);

    logic        out_valid_reg;
    status_t     status_reg, status_next;
    logic [15:0] mtype_reg;
    logic [15:0] minor_reg;
    logic [31:0] flags_reg;
    logic [31:0] size_reg;
    logic [63:0] seq_reg;
    logic [63:0] corr_reg;
    logic [63:0] conn_low_reg;
    logic [63:0] conn_high_reg;

    logic [32:0] expected;
    logic [32:0] count_ext;
    logic        type_bad;
    logic        show;

    assign pop       = !q_stat.empty && (!out_valid_reg || out_ch.ready);
    assign expected  = {1'b0, head_rec.size} + 33'(HEADER_LEN);
    assign count_ext = 33'(head_count);
    assign type_bad  = (head_rec.mtype[15:4] != 12'd0)
                       || !cfg.known_type_mask[head_rec.mtype[3:0]];

    always_comb
    begin
        if (head_count < COUNT_WIDTH'(HEADER_LEN))
            status_next = ST_HDR_TRUNC;
        else if (!head_rec.magic_good)
            status_next = ST_MAGIC;
        else if (!head_rec.length_ok)
            status_next = ST_HDR_SIZE;
        else if (head_rec.major != cfg.major_version)
            status_next = ST_MAJOR;
        else if (type_bad)
            status_next = ST_TYPE;
        else if (head_rec.size > {15'd0, cfg.payload_limit})
            status_next = ST_TOO_LARGE;
        else if (head_rec.rsv_low_nz)
            status_next = ST_RESERVED0;
        else if (head_rec.rsv_high_nz)
            status_next = ST_RESERVED1;
        else if (head_rec.seq == 64'd0)
            status_next = ST_ZERO_SEQ;
        else if (count_ext < expected)
            status_next = ST_PLD_TRUNC;
        else if (count_ext > expected)
            status_next = ST_TRAILING;
        else
            status_next = ST_OK;
    end

    // fields are blanked when the header never got far enough to trust
    assign show = (status_next != ST_HDR_TRUNC) && (status_next != ST_MAGIC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg    <= status_next;
            mtype_reg     <= show ? head_rec.mtype     : 16'd0;
            minor_reg     <= show ? head_rec.minor     : 16'd0;
            flags_reg     <= show ? head_rec.flags     : 32'd0;
            size_reg      <= show ? head_rec.size      : 32'd0;
            seq_reg       <= show ? head_rec.seq       : 64'd0;
            corr_reg      <= show ? head_rec.corr      : 64'd0;
            conn_low_reg  <= show ? head_rec.conn_low  : 64'd0;
            conn_high_reg <= show ? head_rec.conn_high : 64'd0;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.status          = status_reg;
    assign out_ch.msg_type        = mtype_reg;
    assign out_ch.minor_version   = minor_reg;
    assign out_ch.header_flags    = flags_reg;
    assign out_ch.payload_size    = size_reg;
    assign out_ch.sequence_number = seq_reg;
    assign out_ch.correlation_tag = corr_reg;
    assign out_ch.connection_low  = conn_low_reg;
    assign out_ch.connection_high = conn_high_reg;

endmodule

`default_nettype wire

/* rtl/message_header_deframer.sv */
// ----------------------------------------------------------------------------
// message_header_deframer
// Checks and decodes the 64-byte header of a byte-serial message.
// ----------------------------------------------------------------------------
// usage
// in_ch carries one message byte per transfer, end_of_buffer set on the final
// byte. one result per message leaves on out_ch: a status and the decoded
// header fields. payload bytes are only counted.
// throughput is one byte per cycle while the queue is not full; the front end
// captures the header byte by byte and the back end judges a whole message as
// it leaves the queue, so even a run of one-byte messages goes through at one
// per cycle while out_ch accepts. a result passes through the queue register
// and then the output register, loaded when the back end pops the queue.
// when out_ch stalls, the output register holds its result, the queue takes up
// to two more messages, and in_ch.ready drops only once the queue is full.
// cfg_we writes register cfg_index from cfg_data; write only while idle.
// reset clears the byte count and header capture, empties the queue and
// loads the register defaults. no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "message_header_deframer_defines.svh"

module message_header_deframer
    import mhd_pkg::*;
#(
    parameter int COUNT_WIDTH = 17
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    mhd_in_if.sink                 in_ch,
    mhd_out_if.source              out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t                   cfg_reg;
    logic                   q_push;
    logic                   q_pop;
    rec_t                   push_rec;
    rec_t                   head_rec;
    logic [COUNT_WIDTH-1:0] push_count;
    logic [COUNT_WIDTH-1:0] head_count;
    q_status_t              q_stat;
    logic                   out_blank_st;
    logic                   out_fields_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_word      <= MAGIC_RESET;
            cfg_reg.major_version   <= MAJOR_RESET;
            cfg_reg.payload_limit   <= LIMIT_RESET;
            cfg_reg.known_type_mask <= TYPES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAGIC: cfg_reg.magic_word      <= cfg_data;
                CFG_MAJOR: cfg_reg.major_version   <= cfg_data[15:0];
                CFG_LIMIT: cfg_reg.payload_limit   <= cfg_data[16:0];
                CFG_TYPES: cfg_reg.known_type_mask <= cfg_data[15:0];
                default:   cfg_reg <= cfg_reg;
            endcase
        end
    end

    mhd_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg_reg),
        .q_full    (q_stat.full),
        .push      (q_push),
        .rec       (push_rec),
        .rec_count (push_count)
    );

    mhd_queue #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_rec   (push_rec),
        .push_count (push_count),
        .pop        (q_pop),
        .head_rec   (head_rec),
        .head_count (head_count),
        .stat       (q_stat)
    );

    mhd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_stat     (q_stat),
        .head_rec   (head_rec),
        .head_count (head_count),
        .pop        (q_pop),
        .out_ch     (out_ch)
    );

    assign out_blank_st    = (out_ch.status == ST_HDR_TRUNC) || (out_ch.status == ST_MAGIC);
    assign out_fields_zero = (out_ch.sequence_number == 64'd0)
                             && (out_ch.connection_low == 64'd0)
                             && (out_ch.connection_high == 64'd0);

    // a finished message never lands on a full queue
    `MHD_ASSERT_IMPLY(a_no_overflow, q_push, !q_stat.full)

    // a pushed message is waiting in the queue in the following cycle
    `MHD_ASSERT_NEXT(a_push_lands, q_push, !q_stat.empty)

    // header-truncated and magic results carry blank fields
    `MHD_ASSERT_IMPLY(a_blank_fields, out_ch.valid && out_blank_st, out_fields_zero)

    // an ok result always has a non-zero sequence
    `MHD_ASSERT_IMPLY(a_ok_has_seq, out_ch.valid && out_ch.status == ST_OK, out_ch.sequence_number != 64'd0)

endmodule

`default_nettype wire
